// ===== rtl/core/ssa_pkg.sv =====
package ssa_pkg;

  localparam int MAX_SLOTS_DEF        = 1024;
  localparam int SECTORS_PER_SLOT_DEF = 8;

  localparam int COUNT_W   = 11;
  localparam int INDEX_W   = 10;
  localparam int STATUS_W  = 2;
  localparam int SLOTNUM_W = 10;
  localparam int SECTOR_W  = 13;
  localparam int LIMIT_W   = 12;

  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = COUNT_W'(1024);

  // The bitmap is held as 32-bit rows.
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    CLS_ALLOC,
    CLS_FREE,
    CLS_BAD
  } cls_e;

  typedef struct packed {
    logic valid;
    cls_e cls;
  } req_t;

endpackage

// ===== rtl/core/ssa_front.sv =====
module ssa_front #(
  parameter int MAX_SLOTS = ssa_pkg::MAX_SLOTS_DEF,
  parameter int SLOT_W    = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [ssa_pkg::INDEX_W-1:0] slot_index_i,
  output ssa_pkg::req_t               req_o,
  output logic [SLOT_W-1:0]           slot_o,
  input  logic                        pop_i
);

  ssa_pkg::cls_e       cls_q  [2];
  logic [SLOT_W-1:0]   slot_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;

  ssa_pkg::cls_e       cls_in;
  logic [16:0]         idx_ext;
  logic                push;
  logic                pop;

  assign idx_ext = 17'(slot_index_i);

  // A release beyond the bitmap can never name a used slot.
  always_comb begin
    if (command_i == ssa_pkg::CMD_ALLOC) begin
      cls_in = ssa_pkg::CLS_ALLOC;
    end else if (idx_ext >= 17'(MAX_SLOTS)) begin
      cls_in = ssa_pkg::CLS_BAD;
    end else begin
      cls_in = ssa_pkg::CLS_FREE;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cls_q[wr_ptr_q]  <= cls_in;
      slot_q[wr_ptr_q] <= idx_ext[SLOT_W-1:0];
    end
  end

  assign req_o.valid = (cnt_q != 2'd0);
  assign req_o.cls   = cls_q[rd_ptr_q];
  assign slot_o      = slot_q[rd_ptr_q];

endmodule

// ===== rtl/core/ssa_back.sv =====
module ssa_back #(
  parameter int MAX_SLOTS        = ssa_pkg::MAX_SLOTS_DEF,
  parameter int SECTORS_PER_SLOT = ssa_pkg::SECTORS_PER_SLOT_DEF,
  parameter int SLOT_W           = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssa_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  ssa_pkg::req_t                 req_i,
  input  logic [SLOT_W-1:0]             slot_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ssa_pkg::STATUS_W-1:0]  status_o,
  output logic [ssa_pkg::SLOTNUM_W-1:0] slot_number_o,
  output logic [ssa_pkg::SECTOR_W-1:0]  sector_number_o,
  output logic                          last_o
);

  localparam int DEPTH = (MAX_SLOTS < 2048) ? MAX_SLOTS : 2048;
  localparam int ROWS  = (DEPTH + ssa_pkg::WORD_BITS - 1) / ssa_pkg::WORD_BITS;
  localparam int ROW_W = SLOT_W - ssa_pkg::BIT_W;
  localparam int K_W   = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
  localparam int WB    = ssa_pkg::WORD_BITS;
  localparam int BW    = ssa_pkg::BIT_W;
  localparam int LW    = ssa_pkg::LIMIT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [ssa_pkg::COUNT_W-1:0]   count_q;
  ssa_pkg::cls_e                 cls_q, cls_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [BW-1:0]                 bit_q, bit_d;
  logic [SLOT_W-1:0]             em_slot_q, em_slot_d;
  logic [ssa_pkg::STATUS_W-1:0]  em_status_q, em_status_d;
  logic                          em_err_q, em_err_d;
  logic [ssa_pkg::SECTOR_W-1:0]  sec_q, sec_d;
  logic [K_W-1:0]                k_q, k_d;

  logic [WB-1:0]                 mem [ROWS];
  logic [ROWS-1:0]               row_vld_q;
  logic [WB-1:0]                 rd_data_q;
  logic                          rd_vld_q;
  logic [ROW_W-1:0]              rd_addr;
  logic                          wr_en;
  logic [WB-1:0]                 wr_data;

  logic                          out_valid_q;
  logic [ssa_pkg::STATUS_W-1:0]  status_q;
  logic [ssa_pkg::SLOTNUM_W-1:0] slot_num_q;
  logic [ssa_pkg::SECTOR_W-1:0]  sector_q;
  logic                          last_q;

  logic [LW-1:0]                 lim;
  logic [16:0]                   cnt_ext;
  logic [WB-1:0]                 word;
  logic [WB-1:0]                 elig;
  logic [WB-1:0]                 free;
  logic [WB-1:0]                 lowest;
  logic [BW-1:0]                 fbit;
  logic [LW-1:0]                 row_base;
  logic [LW-1:0]                 next_base;
  logic                          last_row;
  logic [WB-1:0]                 onehot;
  logic                          load;
  logic                          em_last;
  logic [31:0]                   base_prod;
  logic [16:0]                   slot_ext;

  // Slot counts above the bitmap size act as the bitmap size.
  assign cnt_ext = 17'(count_q);
  assign lim     = (cnt_ext > 17'(DEPTH)) ? LW'(DEPTH) : LW'(count_q);

  assign word      = rd_vld_q ? rd_data_q : '0;
  assign row_base  = LW'({row_q, {BW{1'b0}}});
  assign next_base = row_base + LW'(WB);
  assign last_row  = (next_base >= lim);

  always_comb begin
    for (int b = 0; b < WB; b++) begin
      elig[b] = ((row_base + LW'(b)) < lim);
    end
  end

  assign free   = ~word & elig;
  assign lowest = free & (~free + WB'(1));

  always_comb begin
    fbit = '0;
    for (int b = 0; b < WB; b++) begin
      if (lowest[b]) begin
        fbit = fbit | BW'(b);
      end
    end
  end

  always_comb begin
    onehot = '0;
    if (cls_q == ssa_pkg::CLS_ALLOC) begin
      onehot[fbit] = 1'b1;
    end else begin
      onehot[bit_q] = 1'b1;
    end
  end

  assign em_last = em_err_q || (k_q == K_W'(SECTORS_PER_SLOT - 1));
  assign load    = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    cls_d       = cls_q;
    row_d       = row_q;
    bit_d       = bit_q;
    em_slot_d   = em_slot_q;
    em_status_d = em_status_q;
    em_err_d    = em_err_q;
    k_d         = k_q;
    pop_o       = 1'b0;
    rd_addr     = row_q;
    wr_en       = 1'b0;
    wr_data     = word;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          pop_o = 1'b1;
          cls_d = req_i.cls;
          k_d   = '0;
          case (req_i.cls)
            ssa_pkg::CLS_ALLOC: begin
              if (lim == '0) begin
                em_status_d = ssa_pkg::ST_FULL;
                em_err_d    = 1'b1;
                em_slot_d   = '0;
                state_d     = S_EMIT;
              end else begin
                rd_addr = '0;
                row_d   = '0;
                state_d = S_CHECK;
              end
            end
            ssa_pkg::CLS_FREE: begin
              rd_addr = slot_i[SLOT_W-1:BW];
              row_d   = slot_i[SLOT_W-1:BW];
              bit_d   = slot_i[BW-1:0];
              state_d = S_CHECK;
            end
            default: begin
              em_status_d = ssa_pkg::ST_NOT_USED;
              em_err_d    = 1'b1;
              em_slot_d   = '0;
              state_d     = S_EMIT;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (cls_q == ssa_pkg::CLS_ALLOC) begin
          if (free != '0) begin
            wr_en       = 1'b1;
            wr_data     = word | onehot;
            em_slot_d   = {row_q, fbit};
            em_status_d = ssa_pkg::ST_OK;
            em_err_d    = 1'b0;
            state_d     = S_EMIT;
          end else if (last_row) begin
            em_slot_d   = '0;
            em_status_d = ssa_pkg::ST_FULL;
            em_err_d    = 1'b1;
            state_d     = S_EMIT;
          end else begin
            // One row per cycle: the next row is read while this one is checked.
            row_d   = row_q + ROW_W'(1);
            rd_addr = row_q + ROW_W'(1);
          end
        end else if (word[bit_q]) begin
          wr_en       = 1'b1;
          wr_data     = word & ~onehot;
          em_slot_d   = {row_q, bit_q};
          em_status_d = ssa_pkg::ST_OK;
          em_err_d    = 1'b0;
          state_d     = S_EMIT;
        end else begin
          em_slot_d   = '0;
          em_status_d = ssa_pkg::ST_NOT_USED;
          em_err_d    = 1'b1;
          state_d     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (load) begin
          k_d = k_q + K_W'(1);
          if (em_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The first sector of a slot is set up as the slot is chosen.
  assign base_prod = 32'(em_slot_d) * 32'(SECTORS_PER_SLOT);

  always_comb begin
    sec_d = sec_q;
    if (state_q != S_EMIT) begin
      sec_d = base_prod[ssa_pkg::SECTOR_W-1:0];
    end else if (load) begin
      sec_d = sec_q + ssa_pkg::SECTOR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= ssa_pkg::SLOT_COUNT_RST;
      row_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= row_vld_q[rd_addr];
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        row_vld_q[row_q] <= 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[row_q] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign slot_ext = 17'(em_slot_q);

  always_ff @(posedge clk_i) begin
    cls_q       <= cls_d;
    row_q       <= row_d;
    bit_q       <= bit_d;
    em_slot_q   <= em_slot_d;
    em_status_q <= em_status_d;
    em_err_q    <= em_err_d;
    k_q         <= k_d;
    sec_q       <= sec_d;
    if (load) begin
      status_q   <= em_status_q;
      slot_num_q <= slot_ext[ssa_pkg::SLOTNUM_W-1:0];
      sector_q   <= em_err_q ? '0 : sec_q;
      last_q     <= em_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign slot_number_o   = slot_num_q;
  assign sector_number_o = sector_q;
  assign last_o          = last_q;

endmodule

// ===== rtl/core/swap_slot_allocator_top.sv =====
// Flow: an accepted item waits in a two-entry queue until the engine is idle; an allocate then
// scans one 32-slot bitmap row per cycle, a release reads its row once.
// Results: SECTORS_PER_SLOT (8 by default) on success and one on error; the engine takes the next
// item only once the last result of the current one is loaded into the result register.
// Reset: every slot reads as free through per-row valid bits, with no clearing pass, and
// slot_count returns to 1024.
module swap_slot_allocator_top #(
  parameter int MAX_SLOTS        = ssa_pkg::MAX_SLOTS_DEF,
  parameter int SECTORS_PER_SLOT = ssa_pkg::SECTORS_PER_SLOT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssa_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [ssa_pkg::INDEX_W-1:0]   slot_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ssa_pkg::STATUS_W-1:0]  status_o,
  output logic [ssa_pkg::SLOTNUM_W-1:0] slot_number_o,
  output logic [ssa_pkg::SECTOR_W-1:0]  sector_number_o,
  output logic                          last_o
);

  localparam int DEPTH  = (MAX_SLOTS < 2048) ? MAX_SLOTS : 2048;
  localparam int ROWS   = (DEPTH + ssa_pkg::WORD_BITS - 1) / ssa_pkg::WORD_BITS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = ROW_W + ssa_pkg::BIT_W;

  ssa_pkg::req_t     req;
  logic [SLOT_W-1:0] req_slot;
  logic              pop;

  ssa_front #(
    .MAX_SLOTS (MAX_SLOTS),
    .SLOT_W    (SLOT_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .slot_index_i (slot_index_i),
    .req_o        (req),
    .slot_o       (req_slot),
    .pop_i        (pop)
  );

  ssa_back #(
    .MAX_SLOTS        (MAX_SLOTS),
    .SECTORS_PER_SLOT (SECTORS_PER_SLOT),
    .SLOT_W           (SLOT_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_i           (req),
    .slot_i          (req_slot),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_number_o   (slot_number_o),
    .sector_number_o (sector_number_o),
    .last_o          (last_o)
  );

endmodule

// ===== tb/slot_result_checker.sv =====
module slot_result_checker
  import ssa_pkg::*;
#(
  parameter int MAX_SLOTS        = MAX_SLOTS_DEF,
  parameter int SECTORS_PER_SLOT = SECTORS_PER_SLOT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [COUNT_W-1:0]   cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 command_i,
  input  logic [INDEX_W-1:0]   slot_index_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [STATUS_W-1:0]  status_i,
  input  logic [SLOTNUM_W-1:0] slot_number_i,
  input  logic [SECTOR_W-1:0]  sector_number_i,
  input  logic                 last_i,
  output int                   pending_o,
  output int                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SLOTNUM_W-1:0] slot;
    logic [SECTOR_W-1:0]  sector;
    logic                 last;
  } sector_result_t;

  bit                 slot_in_use [MAX_SLOTS];
  logic [COUNT_W-1:0] slot_count;
  sector_result_t     sectors_due [$];

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  function automatic void queue_sectors(input int slot);
    sector_result_t r;
    int k;
    for (k = 0; k < SECTORS_PER_SLOT; k++) begin
      r.status = ST_OK;
      r.slot   = SLOTNUM_W'(slot);
      r.sector = SECTOR_W'(slot * SECTORS_PER_SLOT + k);
      r.last   = (k == SECTORS_PER_SLOT - 1);
      sectors_due.push_back(r);
    end
  endfunction

  function automatic void queue_error(input logic [STATUS_W-1:0] status);
    sectors_due.push_back('{status, '0, '0, 1'b1});
  endfunction

  // First fit: the lowest free slot below the effective count, which saturates at MAX_SLOTS.
  function automatic void allocate_or_release(input logic cmd, input logic [INDEX_W-1:0] idx);
    int lim;
    int slot;
    int s;
    if (cmd == CMD_ALLOC) begin
      lim  = (int'(slot_count) > MAX_SLOTS) ? MAX_SLOTS : int'(slot_count);
      slot = -1;
      for (s = 0; s < lim && slot < 0; s++) begin
        if (!slot_in_use[s]) slot = s;
      end
      if (slot < 0) begin
        queue_error(ST_FULL);
      end else begin
        slot_in_use[slot] = 1'b1;
        queue_sectors(slot);
      end
    end else if (int'(idx) >= MAX_SLOTS || !slot_in_use[idx]) begin
      queue_error(ST_NOT_USED);
    end else begin
      // A slot above the current count may still be released if it is in use.
      slot_in_use[idx] = 1'b0;
      queue_sectors(int'(idx));
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sector_result_t want;
    int s;
    if (!rst_ni) begin
      for (s = 0; s < MAX_SLOTS; s++) slot_in_use[s] = 1'b0;
      slot_count = SLOT_COUNT_RST;
      sectors_due.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sectors_due.size() == 0) begin
          $error("unexpected item: status %0d slot %0d sector %0d last %0b",
                 status_i, slot_number_i, sector_number_i, last_i);
          fail_count_o++;
        end else begin
          want = sectors_due.pop_front();
          check_field("status", 16'(want.status), 16'(status_i));
          check_field("slot_number", 16'(want.slot), 16'(slot_number_i));
          check_field("sector_number", 16'(want.sector), 16'(sector_number_i));
          check_field("last", 16'(want.last), 16'(last_i));
        end
      end
      if (cfg_we_i) slot_count = cfg_wdata_i;
      if (in_valid_i && in_ready_i) allocate_or_release(command_i, slot_index_i);
      pending_o = sectors_due.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import ssa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   ITEMS_PER_PHASE = 58;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [COUNT_W-1:0]   cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 command_i;
  logic [INDEX_W-1:0]   slot_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [STATUS_W-1:0]  status_o;
  logic [SLOTNUM_W-1:0] slot_number_o;
  logic [SECTOR_W-1:0]  sector_number_o;
  logic                 last_o;

  int  pending;
  int  fail_count;
  int  results_taken;
  int  allocs_issued;
  bit  sender_gaps_on;

  swap_slot_allocator_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .slot_index_i   (slot_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .slot_number_o  (slot_number_o),
    .sector_number_o(sector_number_o),
    .last_o         (last_o)
  );

  slot_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .command_i      (command_i),
    .slot_index_i   (slot_index_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_i       (status_o),
    .slot_number_i  (slot_number_o),
    .sector_number_i(sector_number_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial results_taken = 0;
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) results_taken++;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a clock edge; returns at the edge where the item is accepted.
  task automatic send_item(input logic cmd, input logic [INDEX_W-1:0] idx);
    int gap;
    gap = sender_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    slot_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // The receiver holds off once for a long stretch while the sender keeps going.
  initial begin : result_sink
    int  n;
    bit  held;
    held        = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held && results_taken >= 400 && in_valid_i) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      n = $urandom_range(1, 24);
      out_ready_i <= 1'b1;
      repeat (n) @(posedge clk_i);
      n = idle_len();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [COUNT_W-1:0] phase_counts [8];
    int p;
    int i;
    int hi;
    phase_counts = '{11'd1024, 11'd5, 11'd1, 11'd40, 11'd2047, 11'd0, 11'd300, 11'd1024};
    in_valid_i     = 1'b0;
    command_i      = CMD_ALLOC;
    slot_index_i   = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    allocs_issued  = 0;
    sender_gaps_on = 1'b1;
    rst_ni         = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Releases of free slots, a hole refilled first fit, all-ones and alternating indexes.
    send_item(CMD_RELEASE, 10'd0);
    send_item(CMD_ALLOC, 10'h3FF);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_ALLOC, 10'h2AA);
    send_item(CMD_RELEASE, 10'd1);
    send_item(CMD_RELEASE, 10'd1);
    send_item(CMD_RELEASE, 10'h3FF);
    send_item(CMD_RELEASE, 10'h2AA);
    send_item(CMD_RELEASE, 10'h155);
    send_item(CMD_ALLOC, 10'h155);
    send_item(CMD_ALLOC, 10'd0);
    wait_results_done();

    // A zero count leaves nothing to allocate, but a slot above it can still be released.
    write_count(11'd0);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_RELEASE, 10'd3);
    send_item(CMD_ALLOC, 10'd0);
    wait_results_done();

    write_count(11'd2);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_RELEASE, 10'd0);
    send_item(CMD_ALLOC, 10'd0);
    wait_results_done();

    // Counts above the slot limit act as the limit.
    write_count(11'd2047);
    send_item(CMD_ALLOC, 10'd0);
    send_item(CMD_ALLOC, 10'd0);
    allocs_issued = 8;

    for (p = 0; p < 8; p++) begin
      wait_results_done();
      write_count(phase_counts[p]);
      sender_gaps_on = (p % 3 != 1);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (i == ITEMS_PER_PHASE / 2) wait_results_done();
        // Used slots stay packed near zero, so most releases aim at most two above the allocations issued.
        hi = (allocs_issued + 2 > 1023) ? 1023 : allocs_issued + 2;
        if ($urandom_range(0, 99) < ((p % 2 == 0) ? 70 : 50)) begin
          send_item(CMD_ALLOC, INDEX_W'($urandom_range(0, 1023)));
          allocs_issued++;
        end else if ($urandom_range(0, 99) < 80) begin
          send_item(CMD_RELEASE, INDEX_W'($urandom_range(0, hi)));
        end else begin
          send_item(CMD_RELEASE, INDEX_W'($urandom_range(0, 1023)));
        end
      end
    end

    wait_results_done();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS swap_slot_allocator_top");
    end else begin
      $display("FAIL swap_slot_allocator_top");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL swap_slot_allocator_top");
    $finish;
  end

endmodule
